[hdl/ddalr_pkg.sv]
// Shared types and constants for the DDA line rasterizer.
`default_nettype none
package ddalr_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    localparam int X_W     = 6;
    localparam int Y_W     = 5;
    localparam int COLOR_W = 8;
    localparam int CNT_W   = X_W;

    localparam logic [X_W-1:0] X_MAX = X_W'(SCREEN_WIDTH - 1);
    localparam logic [Y_W-1:0] Y_MAX = Y_W'(SCREEN_HEIGHT - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [X_W-1:0]     start_x;
        logic [Y_W-1:0]     start_y;
        logic [X_W-1:0]     end_x;
        logic [Y_W-1:0]     end_y;
        logic [COLOR_W-1:0] line_color;
    } line_in_t;

    typedef struct packed {
        logic [X_W-1:0]     pixel_x;
        logic [Y_W-1:0]     pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } pixel_out_t;

    typedef struct packed {
        logic [X_W-1:0]     origin_x;
        logic [Y_W-1:0]     origin_y;
        logic [CNT_W-1:0]   abs_x;
        logic [CNT_W-1:0]   abs_y;
        logic               neg_x;
        logic               neg_y;
        logic [CNT_W-1:0]   count;
        logic [COLOR_W-1:0] color;
    } seg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        DRAW_IDLE,
        DRAW_RUN
    } draw_state_t;

endpackage
`default_nettype wire

[hdl/ddalr_front.sv]
// Front end: accepts segment commands, clamps endpoints and classifies spans.
`default_nettype none
module ddalr_front (
    input  wire logic                    start,
    input  wire ddalr_pkg::line_in_t     segment,
    input  wire ddalr_pkg::queue_status_t status,
    output logic                         busy,
    output logic                         push,
    output ddalr_pkg::seg_t              seg
);
    import ddalr_pkg::*;

    logic [X_W-1:0]   x1;
    logic [X_W-1:0]   x2;
    logic [Y_W-1:0]   y1;
    logic [Y_W-1:0]   y2;
    logic [X_W-1:0]   ax;
    logic [Y_W-1:0]   ay;
    logic             neg_x;
    logic             neg_y;

    always_comb
    begin
        x1 = (segment.start_x > X_MAX) ? X_MAX : segment.start_x;
        x2 = (segment.end_x   > X_MAX) ? X_MAX : segment.end_x;
        y1 = (segment.start_y > Y_MAX) ? Y_MAX : segment.start_y;
        y2 = (segment.end_y   > Y_MAX) ? Y_MAX : segment.end_y;

        neg_x = x2 < x1;
        neg_y = y2 < y1;
        ax    = neg_x ? (x1 - x2) : (x2 - x1);
        ay    = neg_y ? (y1 - y2) : (y2 - y1);

        seg.origin_x = x1;
        seg.origin_y = y1;
        seg.abs_x    = CNT_W'(ax);
        seg.abs_y    = CNT_W'(ay);
        seg.neg_x    = neg_x;
        seg.neg_y    = neg_y;
        seg.count    = (CNT_W'(ax) > CNT_W'(ay)) ? CNT_W'(ax) : CNT_W'(ay);
        seg.color    = segment.line_color;
    end

    assign busy = status.full;
    assign push = start & ~status.full;

endmodule
`default_nettype wire

[hdl/ddalr_queue.sv]
// Two-entry queue of classified segments between front and back ends.
`default_nettype none
module ddalr_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire ddalr_pkg::seg_t         wr_data,
    input  wire logic                    pop,
    output ddalr_pkg::seg_t              rd_data,
    output ddalr_pkg::queue_status_t     status
);
    import ddalr_pkg::*;

    seg_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        status.full  = fill_reg == (QPTR_W+1)'(QUEUE_DEPTH);
        status.empty = fill_reg == '0;
        do_push      = push & ~status.full;
        do_pop       = pop & ~status.empty;

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[hdl/ddalr_back.sv]
// Back end: steps one segment with exact error accumulators, one pixel a cycle while in the run state.
`default_nettype none
module ddalr_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ddalr_pkg::seg_t         seg_in,
    input  wire ddalr_pkg::queue_status_t status,
    output logic                         pop,
    output logic                         strobe,
    output ddalr_pkg::pixel_out_t        pixel
);
    import ddalr_pkg::*;

    draw_state_t      state_reg;
    draw_state_t      state_next;
    seg_t             seg_reg;
    logic [CNT_W-1:0] step_reg;
    logic [X_W-1:0]   qx_reg;
    logic [X_W-1:0]   qx_next;
    logic [CNT_W-1:0] rx_reg;
    logic [CNT_W-1:0] rx_next;
    logic [Y_W-1:0]   qy_reg;
    logic [Y_W-1:0]   qy_next;
    logic [CNT_W-1:0] ry_reg;
    logic [CNT_W-1:0] ry_next;
    logic             strobe_reg;
    logic             strobe_next;
    pixel_out_t       pixel_reg;
    pixel_out_t       pixel_next;

    logic             emit;
    logic             last;
    logic [CNT_W:0]   cnt_ext;
    logic [CNT_W:0]   rx_sum;
    logic [CNT_W:0]   ry_sum;
    logic             x_wrap;
    logic             y_wrap;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DRAW_IDLE:
            begin
                if (!status.empty)
                begin
                    state_next = DRAW_RUN;
                end
            end
            DRAW_RUN:
            begin
                if (last)
                begin
                    state_next = DRAW_IDLE;
                end
            end
            default: state_next = DRAW_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            DRAW_IDLE: pop  = ~status.empty;
            DRAW_RUN:  emit = 1'b1;
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    // offset(i) = delta*i/count: q is the quotient, r the remainder
    always_comb
    begin
        last    = step_reg == seg_reg.count;
        cnt_ext = {1'b0, seg_reg.count};
        rx_sum  = {1'b0, rx_reg} + {1'b0, seg_reg.abs_x};
        ry_sum  = {1'b0, ry_reg} + {1'b0, seg_reg.abs_y};
        x_wrap  = rx_sum >= cnt_ext;
        y_wrap  = ry_sum >= cnt_ext;
        rx_next = x_wrap ? CNT_W'(rx_sum - cnt_ext) : CNT_W'(rx_sum);
        ry_next = y_wrap ? CNT_W'(ry_sum - cnt_ext) : CNT_W'(ry_sum);
        qx_next = qx_reg + X_W'(x_wrap);
        qy_next = qy_reg + Y_W'(y_wrap);

        // negative delta rounds toward minus infinity
        pixel_next.pixel_x = seg_reg.neg_x
                           ? seg_reg.origin_x - qx_reg - X_W'(rx_reg != '0)
                           : seg_reg.origin_x + qx_reg;
        pixel_next.pixel_y = seg_reg.neg_y
                           ? seg_reg.origin_y - qy_reg - Y_W'(ry_reg != '0)
                           : seg_reg.origin_y + qy_reg;
        pixel_next.pixel_color = seg_reg.color;
        pixel_next.last_pixel  = last;
        strobe_next            = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= DRAW_IDLE;
            strobe_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (pop)
            begin
                step_reg <= '0;
            end
            else if (emit)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            seg_reg <= seg_in;
            qx_reg  <= '0;
            rx_reg  <= '0;
            qy_reg  <= '0;
            ry_reg  <= '0;
        end
        else if (emit)
        begin
            qx_reg <= qx_next;
            rx_reg <= rx_next;
            qy_reg <= qy_next;
            ry_reg <= ry_next;
        end
        if (emit)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign strobe = strobe_reg;
    assign pixel  = pixel_reg;

endmodule
`default_nettype wire

[hdl/dda_line_rasterizer_top.sv]
// Top level of the DDA line rasterizer.
// A segment is taken at a clock edge with start high and busy low. It yields
// count+1 pixel words, count being the larger of the column and row spans, one
// word per cycle on pixel, marked by strobe; the first word is registered once
// the stepper has popped the segment, and the final one carries last_pixel.
// There is no back-pressure: each word is valid for exactly one cycle and
// must be taken then. A two-entry queue holds segments while the stepper
// draws, so busy is high only while the queue is full. The stepper pops a
// segment in its idle state and then emits its words in the run state, so it
// takes no new segment until the last word of the previous one is out.
`default_nettype none
module dda_line_rasterizer_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ddalr_pkg::line_in_t segment,
    output logic                     strobe,
    output ddalr_pkg::pixel_out_t    pixel
);
    import ddalr_pkg::*;

    queue_status_t q_status;
    seg_t          front_seg;
    seg_t          back_seg;
    logic          push;
    logic          pop;

    ddalr_front u_front (
        .start   (start),
        .segment (segment),
        .status  (q_status),
        .busy    (busy),
        .push    (push),
        .seg     (front_seg)
    );

    ddalr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_seg),
        .pop     (pop),
        .rd_data (back_seg),
        .status  (q_status)
    );

    ddalr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (back_seg),
        .status  (q_status),
        .pop     (pop),
        .strobe  (strobe),
        .pixel   (pixel)
    );

endmodule
`default_nettype wire

[hdl/ddalr_checker.sv]
// Port-level checker for the DDA line rasterizer, bound to the top level.
`default_nettype none
module ddalr_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  strobe,
    input  wire ddalr_pkg::pixel_out_t pixel
);
    import ddalr_pkg::*;

    // words of one segment come in consecutive cycles
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !pixel.last_pixel |=> strobe)
        else $error("segment words not contiguous");

    a_color_held: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !pixel.last_pixel |=> pixel.pixel_color == $past(pixel.pixel_color))
        else $error("color changed within a segment");

    a_step_x: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !pixel.last_pixel |=>
            (pixel.pixel_x == $past(pixel.pixel_x)) ||
            (pixel.pixel_x == $past(pixel.pixel_x) + X_W'(1)) ||
            (pixel.pixel_x == $past(pixel.pixel_x) - X_W'(1)))
        else $error("column moved more than one step");

    a_step_y: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !pixel.last_pixel |=>
            (pixel.pixel_y == $past(pixel.pixel_y)) ||
            (pixel.pixel_y == $past(pixel.pixel_y) + Y_W'(1)) ||
            (pixel.pixel_y == $past(pixel.pixel_y) - Y_W'(1)))
        else $error("row moved more than one step");

endmodule

bind dda_line_rasterizer_top ddalr_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .pixel  (pixel)
);
`default_nettype wire

[tb/raster_checker.sv]
// Checker for the line rasterizer: predicts pixel words per segment and compares.
`timescale 1ns / 1ps
module raster_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  ddalr_pkg::line_in_t   segment,
    input  wire logic             strobe,
    input  ddalr_pkg::pixel_out_t pixel,
    output int                    mismatches,
    output int                    pending
);
    import ddalr_pkg::*;

    pixel_out_t expected_pixels[$];

    // exact floor(delta * i / n), n > 0
    function automatic int floor_step(int delta, int i, int n);
        if (delta >= 0)
        begin
            return (delta * i) / n;
        end
        return -(((-delta) * i + n - 1) / n);
    endfunction

    function automatic void trace_segment(line_in_t seg);
        int         x1, y1, x2, y2;
        int         dx, dy, ax, ay, n, i, px, py;
        pixel_out_t p;
        x1 = (int'(seg.start_x) > int'(X_MAX)) ? int'(X_MAX) : int'(seg.start_x);
        y1 = (int'(seg.start_y) > int'(Y_MAX)) ? int'(Y_MAX) : int'(seg.start_y);
        x2 = (int'(seg.end_x) > int'(X_MAX)) ? int'(X_MAX) : int'(seg.end_x);
        y2 = (int'(seg.end_y) > int'(Y_MAX)) ? int'(Y_MAX) : int'(seg.end_y);
        dx = x2 - x1;
        dy = y2 - y1;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        n  = (ax > ay) ? ax : ay;
        if (n > 63)
        begin
            n = 63;
        end
        for (i = 0; i <= n; i++)
        begin
            px = x1;
            py = y1;
            if (n > 0)
            begin
                px = x1 + floor_step(dx, i, n);
                py = y1 + floor_step(dy, i, n);
            end
            p.pixel_x     = px[X_W-1:0];
            p.pixel_y     = py[Y_W-1:0];
            p.pixel_color = seg.line_color;
            p.last_pixel  = (i == n);
            expected_pixels.push_back(p);
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                trace_segment(segment);
            end
            if (strobe)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h", $time, pixel);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel.pixel_x !== want.pixel_x)
                    begin
                        $display("%0t: pixel_x expected %0d actual %0d",
                                 $time, want.pixel_x, pixel.pixel_x);
                        mismatches++;
                    end
                    if (pixel.pixel_y !== want.pixel_y)
                    begin
                        $display("%0t: pixel_y expected %0d actual %0d",
                                 $time, want.pixel_y, pixel.pixel_y);
                        mismatches++;
                    end
                    if (pixel.pixel_color !== want.pixel_color)
                    begin
                        $display("%0t: pixel_color expected %h actual %h",
                                 $time, want.pixel_color, pixel.pixel_color);
                        mismatches++;
                    end
                    if (pixel.last_pixel !== want.last_pixel)
                    begin
                        $display("%0t: last_pixel expected %b actual %b",
                                 $time, want.last_pixel, pixel.last_pixel);
                        mismatches++;
                    end
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the line rasterizer: drives segments and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import ddalr_pkg::*;

    localparam int RANDOM_SEGS = 280;
    localparam int QUIET_TAIL  = 40;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    line_in_t   segment;
    logic       strobe;
    pixel_out_t pixel;
    int         mismatches;
    int         pending;
    int         cycle_cnt = 0;

    dda_line_rasterizer_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .segment (segment),
        .strobe  (strobe),
        .pixel   (pixel)
    );

    raster_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .segment    (segment),
        .strobe     (strobe),
        .pixel      (pixel),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic line_in_t make_seg(int sx, int sy, int ex, int ey, int c);
        line_in_t s;
        s.start_x    = sx[X_W-1:0];
        s.start_y    = sy[Y_W-1:0];
        s.end_x      = ex[X_W-1:0];
        s.end_y      = ey[Y_W-1:0];
        s.line_color = c[COLOR_W-1:0];
        return s;
    endfunction

    function automatic line_in_t random_seg();
        int sx, sy, ex, ey, c, kind;
        sx   = $urandom_range(0, 63);
        sy   = $urandom_range(0, 31);
        c    = $urandom_range(0, 255);
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            // short segment, wraps at the screen edge
            ex = (sx + $urandom_range(0, 14) - 7) & 63;
            ey = (sy + $urandom_range(0, 14) - 7) & 31;
        end
        else if (kind < 80)
        begin
            ex = $urandom_range(0, 63);
            ey = $urandom_range(0, 31);
        end
        else if (kind < 88)
        begin
            ex = $urandom_range(0, 63);
            ey = sy;
        end
        else if (kind < 95)
        begin
            ex = sx;
            ey = $urandom_range(0, 31);
        end
        else
        begin
            ex = sx;
            ey = sy;
        end
        return make_seg(sx, sy, ex, ey, c);
    endfunction

    task automatic send_segment(line_in_t s, bit allow_gap);
        int gap;
        if (allow_gap && ($urandom_range(0, 99) < 30))
        begin
            gap = $urandom_range(1, 14);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start   <= 1'b1;
        segment <= s;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    line_in_t directed[$];

    initial
    begin
        start   = 1'b0;
        segment = '0;
        rst_n   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(make_seg(0, 0, 0, 0, 8'h00));
        directed.push_back(make_seg(63, 31, 63, 31, 8'hFF));
        directed.push_back(make_seg(0, 0, 63, 0, 8'hAA));
        directed.push_back(make_seg(63, 0, 0, 0, 8'h55));
        directed.push_back(make_seg(0, 0, 0, 31, 8'h01));
        directed.push_back(make_seg(0, 31, 0, 0, 8'h80));
        directed.push_back(make_seg(0, 0, 63, 31, 8'h7F));
        directed.push_back(make_seg(63, 31, 0, 0, 8'hFE));
        directed.push_back(make_seg(0, 31, 63, 0, 8'h3C));
        directed.push_back(make_seg(63, 0, 0, 31, 8'hC3));
        directed.push_back(make_seg(5, 5, 6, 7, 8'h11));
        directed.push_back(make_seg(10, 20, 3, 2, 8'h22));
        directed.push_back(make_seg(20, 3, 21, 3, 8'h33));
        directed.push_back(make_seg(31, 15, 32, 16, 8'h44));
        directed.push_back(make_seg(40, 10, 33, 30, 8'h66));
        directed.push_back(make_seg(0, 16, 31, 15, 8'h99));
        directed.push_back(make_seg(32, 0, 31, 31, 8'hF0));
        directed.push_back(make_seg(17, 9, 17, 9, 8'h0F));

        foreach (directed[k])
        begin
            send_segment(directed[k], k % 3 == 1);
        end
        for (int k = 0; k < RANDOM_SEGS; k++)
        begin
            send_segment(random_seg(), k < RANDOM_SEGS - QUIET_TAIL);
        end
        @(negedge clk);
        start <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (70) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/ddalr_pkg.sv
hdl/ddalr_front.sv
hdl/ddalr_queue.sv
hdl/ddalr_back.sv
hdl/dda_line_rasterizer_top.sv
hdl/ddalr_checker.sv
tb/raster_checker.sv
tb/tb_top.sv
